/* hw/rtl/ked_pkg.sv */
// ============================================================================
// ked_pkg: shared types and constants of the key event detector
// Configuration, per-lane event and pop result types, register indexes and
// event kind codes.
// ============================================================================
package ked_pkg;

  // Configuration port widths.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_EVENT_ENABLE_MASK = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_MS     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_MS         = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TICK_MS           = 2'd3;

  // Register reset values.
  localparam logic [11:0] MASK_RESET       = 12'd4095;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;
  localparam logic [15:0] REPEAT_RESET     = 16'd100;
  localparam logic [7:0]  TICK_RESET       = 8'd10;

  // Event kinds, the low two bits of an event code.
  localparam logic [1:0] KIND_RELEASE = 2'd0;
  localparam logic [1:0] KIND_PRESS   = 2'd1;
  localparam logic [1:0] KIND_LONG    = 2'd2;
  localparam logic [1:0] KIND_REPEAT  = 2'd3;

  localparam logic [15:0] TIMER_MAX = 16'hFFFF;

  typedef struct packed {
    logic [11:0] event_enable_mask;
    logic [15:0] long_press_ms;
    logic [15:0] repeat_ms;
    logic [7:0]  tick_ms;
  } ked_cfg_t;

  // One lane's push request for the current scan tick.
  typedef struct packed {
    logic       push;
    logic [3:0] code;
  } ked_evt_t;

  // Outcome of one pop.
  typedef struct packed {
    logic       valid;
    logic [3:0] code;
  } ked_res_t;

endpackage

/* hw/rtl/ked_lane.sv */
// ============================================================================
// ked_lane: per-key press, long press, repeat and release detector
// One copy runs for each key. On each scan tick it advances the key's phase
// and timers and raises at most one enabled event push.
// ============================================================================
module ked_lane
  import ked_pkg::*;
#(
  parameter int KEY_ID = 0
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     tick,
  input  logic     released,
  input  ked_cfg_t cfg,
  output ked_evt_t evt
);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PRESS   = 2'd1;
  localparam logic [1:0] PH_HELD    = 2'd2;
  localparam logic [1:0] PH_RELEASE = 2'd3;

  localparam logic [3:0] CODE_BASE = 4'(KEY_ID * 4);

  logic [1:0]  phase, phase_next;
  logic        last_level;
  logic [15:0] hold_time, hold_time_next;
  logic [15:0] repeat_time, repeat_time_next;
  logic [16:0] hold_sum, repeat_sum;
  logic [15:0] hold_sat, repeat_sat;
  logic [3:0]  enable_bits;
  logic [1:0]  kind;
  logic        fire;

  // Saturating timer increments.
  assign hold_sum   = {1'b0, hold_time} + {9'd0, cfg.tick_ms};
  assign repeat_sum = {1'b0, repeat_time} + {9'd0, cfg.tick_ms};
  assign hold_sat   = hold_sum[16] ? TIMER_MAX : hold_sum[15:0];
  assign repeat_sat = repeat_sum[16] ? TIMER_MAX : repeat_sum[15:0];

  assign enable_bits = cfg.event_enable_mask[KEY_ID*4 +: 4];

  // Phase machine for one scan tick.
  always_comb begin
    phase_next       = phase;
    hold_time_next   = hold_time;
    repeat_time_next = repeat_time;
    kind             = KIND_PRESS;
    fire             = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (!released && last_level) begin
          phase_next = PH_PRESS;
        end
      end
      PH_PRESS: begin
        if (!released) begin
          fire       = 1'b1;
          kind       = KIND_PRESS;
          phase_next = PH_HELD;
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_HELD: begin
        if (released) begin
          phase_next = PH_RELEASE;
        end else if (cfg.long_press_ms != 16'd0) begin
          if (hold_time < cfg.long_press_ms) begin
            hold_time_next = hold_sat;
            if (hold_sat >= cfg.long_press_ms) begin
              fire = 1'b1;
              kind = KIND_LONG;
            end
          end else if (cfg.repeat_ms != 16'd0) begin
            repeat_time_next = repeat_sat;
            if (repeat_sat >= cfg.repeat_ms) begin
              fire             = 1'b1;
              kind             = KIND_REPEAT;
              repeat_time_next = 16'd0;
            end
          end
        end
      end
      PH_RELEASE: begin
        if (released) begin
          fire             = 1'b1;
          kind             = KIND_RELEASE;
          hold_time_next   = 16'd0;
          repeat_time_next = 16'd0;
          phase_next       = PH_IDLE;
        end else begin
          phase_next = PH_HELD;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // The push is qualified by the tick and by the per-event enable bit.
  assign evt.push = tick && fire && enable_bits[kind];
  assign evt.code = CODE_BASE + {2'b00, kind};

  // State update on each accepted scan tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      last_level  <= 1'b1;
      hold_time   <= 16'd0;
      repeat_time <= 16'd0;
    end else if (tick) begin
      phase       <= phase_next;
      last_level  <= released;
      hold_time   <= hold_time_next;
      repeat_time <= repeat_time_next;
    end
  end

endmodule

/* hw/rtl/ked_fifo.sv */
// ============================================================================
// ked_fifo: merging ring FIFO for key events
// Takes the pushes of all lanes together in key order, overwriting the
// oldest entry when full, and returns the oldest event on a pop.
// ============================================================================
module ked_fifo
  import ked_pkg::*;
#(
  parameter int KEY_COUNT  = 3,
  parameter int FIFO_DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ked_evt_t [KEY_COUNT-1:0] evts,
  input  logic                     pop,
  output ked_res_t                 pop_result
);

  localparam int PTR_W = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);

  logic [3:0]       store [FIFO_DEPTH];
  logic [PTR_W-1:0] read_ptr, read_ptr_next;
  logic [PTR_W-1:0] write_ptr, write_ptr_next;
  logic [PTR_W-1:0] waddr [KEY_COUNT];
  logic             empty;
  logic             any_push;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    wrap_inc = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  assign empty = (read_ptr == write_ptr);

  // Place the pushes one after another; a push that catches up with the
  // read pointer drops the oldest event.
  always_comb begin
    read_ptr_next  = read_ptr;
    write_ptr_next = write_ptr;
    any_push       = 1'b0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      waddr[k] = write_ptr_next;
      if (evts[k].push) begin
        any_push       = 1'b1;
        write_ptr_next = wrap_inc(write_ptr_next);
        if (write_ptr_next == read_ptr_next) begin
          read_ptr_next = wrap_inc(read_ptr_next);
        end
      end
    end
    if (pop && !empty) begin
      read_ptr_next = wrap_inc(read_ptr);
    end
  end

  // Pop result from the oldest entry.
  always_comb begin
    pop_result.valid = 1'b0;
    pop_result.code  = 4'd0;
    if (pop && !empty) begin
      pop_result.valid = 1'b1;
      pop_result.code  = store[read_ptr];
    end
  end

  // Event store writes; a later key wins where two land on one entry.
  always_ff @(posedge clk) begin
    for (int k = 0; k < KEY_COUNT; k++) begin
      if (evts[k].push) begin
        store[waddr[k]] <= evts[k].code;
      end
    end
  end

  // Pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      read_ptr  <= '0;
      write_ptr <= '0;
    end else begin
      read_ptr  <= read_ptr_next;
      write_ptr <= write_ptr_next;
    end
  end

  // After any push the FIFO cannot look empty.
  a_push_not_empty: assert property (@(posedge clk) disable iff (rst)
    any_push |=> (read_ptr != write_ptr))
    else $error("FIFO looks empty after a push");

  // A pop on a non-empty FIFO advances the read pointer by one.
  a_pop_advance: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !any_push) |=> (read_ptr == wrap_inc($past(read_ptr))))
    else $error("read pointer did not advance on pop");

  // A pop reports valid exactly when the FIFO holds an event.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> (pop_result.valid == !empty))
    else $error("pop valid disagrees with FIFO occupancy");

endmodule

/* hw/rtl/key_event_detector_with_fifo_unit.sv */
// ============================================================================
// key_event_detector_with_fifo_unit: key event detector with event FIFO
// Scan ticks run every key's detector lane side by side and merge their
// events into a ring FIFO; pop items return the oldest event.
// ============================================================================
//
//  Channel   Handshake                  Payload
//  --------  -------------------------  ---------------------------------
//  input     in_valid / in_stall        mode, key_levels
//  output    out_valid / out_stall      event_valid, event_code
//  config    cfg_write_enable           cfg_index, cfg_data
//
// One item is accepted per cycle while in_stall is low. Scan ticks and pops
// act at the edge that accepts them: a tick updates all lanes and the FIFO;
// a pop result is registered in the output stage. It holds two results, and
// in_stall rises only while both are occupied. Synchronous reset clears the
// lanes, pointers and output stage at once; the event store needs no pass.
//
module key_event_detector_with_fifo_unit
  import ked_pkg::*;
#(
  parameter int KEY_COUNT  = 3,
  parameter int FIFO_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   mode,
  input  logic [2:0]             key_levels,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   event_valid,
  output logic [3:0]             event_code,
  input  logic                   cfg_write_enable,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  ked_cfg_t                 cfg;
  ked_evt_t [KEY_COUNT-1:0] evts;
  ked_res_t                 pop_result;
  ked_res_t                 main_res, skid_res;
  logic                     skid_valid;
  logic                     in_transfer;
  logic                     tick;
  logic                     pop;
  logic                     out_transfer;

  assign in_stall     = skid_valid;
  assign in_transfer  = in_valid && !in_stall;
  assign tick         = in_transfer && !mode;
  assign pop          = in_transfer && mode;
  assign out_transfer = out_valid && !out_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.event_enable_mask <= MASK_RESET;
      cfg.long_press_ms     <= LONG_PRESS_RESET;
      cfg.repeat_ms         <= REPEAT_RESET;
      cfg.tick_ms           <= TICK_RESET;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_EVENT_ENABLE_MASK: cfg.event_enable_mask <= cfg_data[11:0];
        REG_LONG_PRESS_MS:     cfg.long_press_ms     <= cfg_data;
        REG_REPEAT_MS:         cfg.repeat_ms         <= cfg_data;
        REG_TICK_MS:           cfg.tick_ms           <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // One detector lane per key.
  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_lane
    ked_lane #(
      .KEY_ID (k)
    ) u_lane (
      .clk      (clk),
      .rst      (rst),
      .tick     (tick),
      .released (key_levels[k]),
      .cfg      (cfg),
      .evt      (evts[k])
    );
  end

  // Merging FIFO.
  ked_fifo #(
    .KEY_COUNT  (KEY_COUNT),
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .evts       (evts),
    .pop        (pop),
    .pop_result (pop_result)
  );

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_transfer) begin
      if (skid_valid) begin
        main_res   <= skid_res;
        skid_valid <= 1'b0;
      end else if (pop) begin
        main_res <= pop_result;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (out_valid) begin
      if (pop) begin
        skid_res   <= pop_result;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_res  <= pop_result;
      out_valid <= 1'b1;
    end
  end

  assign event_valid = main_res.valid;
  assign event_code  = main_res.code;

  // The skid stage is only used behind a waiting result.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a result with the output register empty");

  // Every accepted pop shows up in the output stage on the next cycle.
  a_pop_lands: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("accepted pop produced no result");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for key_event_detector_with_fifo_unit
// Drives scan ticks and pops through the valid/stall input channel, predicts
// every key machine and the event ring, and checks each popped event.
// ============================================================================
module testbench;
  import ked_pkg::*;

  localparam int  KEYS             = 3;
  localparam int  RING_DEPTH       = 16;
  localparam logic MODE_SCAN       = 1'b0;
  localparam logic MODE_POP        = 1'b1;
  localparam int  SETTLE_CYCLES    = 4;
  localparam int  HOLD_OFF_CYCLES  = 60;
  localparam int  WATCHDOG_LIMIT   = 1000;
  localparam int  MAX_REPORT_LINES = 40;

  typedef enum logic [1:0] {KEY_IDLE, KEY_PRESSING, KEY_HELD, KEY_RELEASING} key_phase_t;

  // Predicts the key machines and the event ring, and holds the pop results
  // still to come out of the block.
  class key_event_scoreboard;
    logic [11:0] enable_mask;
    logic [15:0] long_press_ms;
    logic [15:0] repeat_ms;
    logic [7:0]  tick_ms;
    key_phase_t  phase [KEYS];
    bit          last_up [KEYS];
    int unsigned hold_ms [KEYS];
    int unsigned repeat_run_ms [KEYS];
    logic [3:0]  event_ring [RING_DEPTH];
    int unsigned rd_ptr;
    int unsigned wr_ptr;
    ked_res_t    expected_pops [$];
    int          errors;
    int          scan_ticks;
    int          pops;
    int          results_checked;
    int          events_popped;
    int          overflows;
    int          register_writes;

    function new();
      enable_mask   = MASK_RESET;
      long_press_ms = LONG_PRESS_RESET;
      repeat_ms     = REPEAT_RESET;
      tick_ms       = TICK_RESET;
      for (int k = 0; k < KEYS; k++) begin
        phase[k]         = KEY_IDLE;
        last_up[k]       = 1'b1;
        hold_ms[k]       = 0;
        repeat_run_ms[k] = 0;
      end
      rd_ptr = 0;
      wr_ptr = 0;
      errors = 0;
      scan_ticks = 0;
      pops = 0;
      results_checked = 0;
      events_popped = 0;
      overflows = 0;
      register_writes = 0;
    endfunction

    task report_mismatch(input string msg);
      if (errors < MAX_REPORT_LINES) $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_EVENT_ENABLE_MASK: enable_mask   = data[11:0];
        REG_LONG_PRESS_MS:     long_press_ms = data;
        REG_REPEAT_MS:         repeat_ms     = data;
        REG_TICK_MS:           tick_ms       = data[7:0];
        default: ;
      endcase
      register_writes++;
    endfunction

    function int unsigned add_sat(int unsigned a, int unsigned b);
      int unsigned s;
      s = a + b;
      return (s > TIMER_MAX) ? TIMER_MAX : s;
    endfunction

    // A full ring drops its oldest entry, so it holds at most depth-1 events.
    function void push_event(int key, logic [1:0] kind);
      logic [3:0] code;
      code = {key[1:0], kind};
      if (!enable_mask[code]) return;
      event_ring[wr_ptr] = code;
      wr_ptr = (wr_ptr + 1) % RING_DEPTH;
      if (wr_ptr == rd_ptr) begin
        rd_ptr = (rd_ptr + 1) % RING_DEPTH;
        overflows++;
      end
    endfunction

    // One scan tick of one key; up is the raw level, 1 meaning released.
    function void scan_key(int k, bit up);
      case (phase[k])
        KEY_IDLE: begin
          if (!up && last_up[k]) phase[k] = KEY_PRESSING;
        end
        KEY_PRESSING: begin
          if (!up) begin
            push_event(k, KIND_PRESS);
            phase[k] = KEY_HELD;
          end else begin
            phase[k] = KEY_IDLE;
          end
        end
        KEY_HELD: begin
          if (up) begin
            phase[k] = KEY_RELEASING;
          end else if (long_press_ms != 0) begin
            // The hold timer runs to the limit first; the repeat timer after.
            if (hold_ms[k] < long_press_ms) begin
              hold_ms[k] = add_sat(hold_ms[k], tick_ms);
              if (hold_ms[k] >= long_press_ms) push_event(k, KIND_LONG);
            end else if (repeat_ms != 0) begin
              repeat_run_ms[k] = add_sat(repeat_run_ms[k], tick_ms);
              if (repeat_run_ms[k] >= repeat_ms) begin
                push_event(k, KIND_REPEAT);
                repeat_run_ms[k] = 0;
              end
            end
          end
        end
        default: begin
          if (up) begin
            push_event(k, KIND_RELEASE);
            hold_ms[k]       = 0;
            repeat_run_ms[k] = 0;
            phase[k]         = KEY_IDLE;
          end else begin
            phase[k] = KEY_HELD;
          end
        end
      endcase
      last_up[k] = up;
    endfunction

    // Notes an accepted input transfer.
    function void accept_item(logic mode_bit, logic [2:0] levels);
      ked_res_t res;
      if (mode_bit == MODE_SCAN) begin
        scan_ticks++;
        for (int k = 0; k < KEYS; k++) scan_key(k, levels[k]);
      end else begin
        pops++;
        if (rd_ptr == wr_ptr) begin
          res.valid = 1'b0;
          res.code  = 4'd0;
        end else begin
          res.valid = 1'b1;
          res.code  = event_ring[rd_ptr];
          rd_ptr = (rd_ptr + 1) % RING_DEPTH;
        end
        expected_pops.push_back(res);
      end
    endfunction

    // Checks one accepted output transfer against the oldest pending pop.
    task check_pop_result(input logic got_valid, input logic [3:0] got_code);
      ked_res_t want;
      if (expected_pops.size() == 0) begin
        report_mismatch($sformatf("result valid=%b code=%0d with no pop pending",
                                  got_valid, got_code));
      end else begin
        want = expected_pops.pop_front();
        results_checked++;
        if (want.valid) events_popped++;
        if (got_valid !== want.valid)
          report_mismatch($sformatf("event_valid %b, predicted %b", got_valid, want.valid));
        if (got_code !== want.code)
          report_mismatch($sformatf("event_code %0d, predicted %0d", got_code, want.code));
      end
    endtask

    task report_leftovers();
      while (expected_pops.size() != 0) begin
        report_mismatch("predicted pop result never arrived");
        void'(expected_pops.pop_front());
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic                   mode;
  logic [2:0]             key_levels;
  logic                   out_valid;
  logic                   out_stall;
  logic                   event_valid;
  logic [3:0]             event_code;
  logic                   cfg_write_enable;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  key_event_scoreboard sb;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_off_request;
  int  hold_offs;
  int  quiet_cycles;
  bit  key_down [KEYS];

  key_event_detector_with_fifo_unit DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .mode             (mode),
    .key_levels       (key_levels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .event_valid      (event_valid),
    .event_code       (event_code),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_request = 1'b0;
        hold_offs++;
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Output monitor and watchdog on cycles with no transfer at all.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_pop_result(event_valid, event_code);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_enable) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
          $display("FAIL key_event_detector_with_fifo_unit");
          $finish;
        end
      end
    end
  end

  // Offers one item, starting at a falling edge, and returns at the falling
  // edge after its transfer with valid still high.
  task automatic send_item(input logic mode_bit, input logic [2:0] levels);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= mode_bit;
    key_levels <= levels;
    do @(posedge clk); while (in_stall);
    sb.accept_item(mode_bit, levels);
    @(negedge clk);
  endtask

  task automatic scan_ticks(input logic [2:0] levels, input int count);
    repeat (count) send_item(MODE_SCAN, levels);
  endtask

  task automatic pop_items(input int count);
    repeat (count) send_item(MODE_POP, 3'($urandom_range(7)));
  endtask

  // Waits until every pop has returned and the block has settled.
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (sb.expected_pops.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= data;
    @(posedge clk);
    sb.write_register(idx, data);
    @(negedge clk);
  endtask

  task automatic configure(input logic [15:0] mask_word, input logic [15:0] long_ms,
                           input logic [15:0] rep_ms, input logic [15:0] tick_word);
    wait_until_idle();
    write_register(REG_EVENT_ENABLE_MASK, mask_word);
    write_register(REG_LONG_PRESS_MS, long_ms);
    write_register(REG_REPEAT_MS, rep_ms);
    write_register(REG_TICK_MS, tick_word);
    cfg_write_enable <= 1'b0;
  endtask

  // Random traffic: keys follow press and release gestures that toggle with
  // probability 1/flip_div per tick, with one-tick glitches as noise.
  task automatic run_random_phase(input int count, input int pop_pct,
                                  input int flip_div, input int glitch_pct);
    logic [2:0] levels;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < pop_pct) begin
        send_item(MODE_POP, 3'($urandom_range(7)));
      end else begin
        for (int k = 0; k < KEYS; k++) begin
          if (flip_div > 0 && $urandom_range(flip_div - 1) == 0) key_down[k] = !key_down[k];
          levels[k] = !key_down[k];
          if ($urandom_range(99) < glitch_pct) levels[k] = !levels[k];
        end
        send_item(MODE_SCAN, levels);
      end
    end
  endtask

  // Main sequence.
  initial begin
    sb = new();
    send_idle_pct    = 15;
    recv_stall_pct   = 15;
    hold_off_request = 1'b0;
    hold_offs        = 0;
    quiet_cycles     = 0;
    for (int k = 0; k < KEYS; k++) key_down[k] = 1'b0;
    rst              = 1'b1;
    in_valid         = 1'b0;
    mode             = MODE_SCAN;
    key_levels       = 3'b111;
    cfg_write_enable = 1'b0;
    cfg_index        = REG_EVENT_ENABLE_MASK;
    cfg_data         = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty pop, the full gesture on all keys at once, then enough
    // events to overflow the ring.
    configure(16'h0FFF, 16'd20, 16'd20, 16'd10);
    pop_items(1);
    scan_ticks(3'b000, 6);
    scan_ticks(3'b111, 2);
    scan_ticks(3'b000, 4);

    // Directed: zero tick with the hold already past a lowered limit, then
    // repeat disabled, long press disabled, and a clipped repeat interval.
    configure(16'h0FFF, 16'd10, 16'd20, 16'd0);
    scan_ticks(3'b000, 1);
    configure(16'h0FFF, 16'd10, 16'd0, 16'd255);
    scan_ticks(3'b000, 1);
    configure(16'h0FFF, 16'd0, 16'hFFFF, 16'd255);
    scan_ticks(3'b000, 1);
    configure(16'h0FFF, 16'd10, 16'd300, 16'd255);
    scan_ticks(3'b000, 2);

    // Directed: release events masked off, junk in unused data bits, and a
    // one-tick press that never confirms.
    configure(16'hFAAA, 16'd10, 16'd300, 16'hFFFF);
    scan_ticks(3'b111, 2);
    scan_ticks(3'b110, 1);
    scan_ticks(3'b111, 1);
    pop_items(4);

    // Short timers with plenty of gestures.
    configure(16'h0FFF, 16'd30, 16'd20, 16'd10);
    run_random_phase(250, 35, 8, 5);

    // A stretch with no idling on either side; long press disabled.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    configure(16'hFFFF, 16'd0, 16'd50, 16'd7);
    run_random_phase(150, 40, 6, 5);
    send_idle_pct  = 15;
    recv_stall_pct = 15;

    // Keys held long enough for the hold timer to clip at its maximum...
    configure(16'h0FFF, 16'hFFFF, 16'hFFFF, 16'd250);
    for (int k = 0; k < KEYS; k++) key_down[k] = 1'b1;
    run_random_phase(340, 15, 0, 2);
    // ...then the limit drops below the hold time and the repeat timer clips.
    configure(16'h0FFF, 16'd200, 16'hFFFF, 16'd250);
    run_random_phase(330, 8, 0, 2);

    // Busy traffic, then a long receiver hold-off that backs up the block.
    configure(16'h0FFF, 16'd20, 16'd10, 16'd10);
    run_random_phase(120, 40, 4, 10);
    hold_off_request = 1'b1;
    pop_items(40);
    run_random_phase(80, 50, 4, 10);

    // All events masked, slowest tick; then a random setting.
    configure(16'h0000, 16'd25, 16'd15, 16'd1);
    run_random_phase(50, 40, 5, 5);
    configure(16'($urandom), 16'($urandom_range(40)), 16'($urandom_range(30)),
              16'($urandom_range(15)));
    run_random_phase(50, 40, 5, 5);

    // Drain and finish.
    wait_until_idle();
    sb.report_leftovers();
    $display("Run covered %0d scan ticks and %0d pops, %0d of which returned an event.",
             sb.scan_ticks, sb.pops, sb.events_popped);
    $display("%0d register writes, %0d ring overflows, %0d receiver hold-offs, %0d errors.",
             sb.register_writes, sb.overflows, hold_offs, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS key_event_detector_with_fifo_unit");
    end else begin
      $display("FAIL key_event_detector_with_fifo_unit");
    end
    $finish;
  end

endmodule
